// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file to check its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge while reset is released.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds while reset is released.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== hw/rtl/tfss_pkg.sv =====
// Shared types, constants and helper functions of the transfer function converter.
`timescale 1ns / 1ps

package tfss_pkg;

    localparam int TFSS_MAX_ORDER = 16;
    localparam int TFSS_DIV_BITS  = 48;   // |x| * 65536 fits in 48 bits
    localparam int TFSS_QUOT_W    = TFSS_DIV_BITS + 1;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NOT_PROPER = 2'd1,
        ST_ORDER_ZERO = 2'd2,
        ST_TOO_MANY   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        RD_SCAN = 2'd0,
        RD_HEAD = 2'd1,
        RD_COL  = 2'd2
    } t_rd_sel;

    typedef enum logic [1:0] {
        DIV_P0 = 2'd0,
        DIV_DK = 2'd1,
        DIV_PK = 2'd2
    } t_div_sel;

    typedef struct packed {
        logic     load;
        logic     cnt_clr;
        logic     idx_clr;
        logic     idx_inc;
        logic     ns_set;
        logic     ds_set;
        logic     chk_set;
        logic     den0_set;
        logic     div_start;
        t_div_sel div_sel;
        logic     p0_set;
        logic     p0_clr;
        logic     k_init;
        logic     k_inc;
        logic     nk_set;
        logic     q_set;
        logic     prod_set;
        logic     pk_set;
        logic     emit;
        logic     err;
        t_status  err_code;
        t_rd_sel  rd_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic ovf;
        logic num_scan_end;
        logic num_small;
        logic den_scan_end;
        logic den_small;
        logic not_proper;
        logic order_zero;
        logic pad_zero;
        logic div_done;
        logic k_last;
    } t_dp_stat;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

endpackage

// ===== hw/rtl/tfss_ram.sv =====
// Generic single write, single read RAM with registered read data.
`timescale 1ns / 1ps

module tfss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 17
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/tfss_div.sv =====
// Iterative signed Q16.16 divider: (x * 65536) / d, truncated toward zero.
`timescale 1ns / 1ps

module tfss_div
    import tfss_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [31:0]            i_x,
    input  logic signed [31:0]            i_d,
    output logic signed [TFSS_QUOT_W-1:0] o_quot,
    output logic                          o_done
);

    localparam int CNT_W = $clog2(TFSS_DIV_BITS);

    logic                          r_run, r_fix, r_done, r_neg;
    logic [CNT_W-1:0]              r_cnt;
    logic [31:0]                   r_rem;
    logic [31:0]                   r_dvs;
    logic [TFSS_DIV_BITS-1:0]      r_dvd;
    logic signed [TFSS_QUOT_W-1:0] r_quot;

    logic [32:0] trial;
    logic        fits;

    assign trial = {r_rem, r_dvd[TFSS_DIV_BITS-1]};
    assign fits  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
                r_rem <= '0;
                r_dvs <= mag32(i_d);
                r_dvd <= {mag32(i_x), 16'd0};
                r_neg <= i_x[31] ^ i_d[31];
            end else if (r_run) begin
                r_rem <= fits ? 32'(trial - {1'b0, r_dvs}) : trial[31:0];
                r_dvd <= {r_dvd[TFSS_DIV_BITS-2:0], fits};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(TFSS_DIV_BITS - 1)) begin
                    r_run <= 1'b0;
                    r_fix <= 1'b1;
                end
            end else if (r_fix) begin
                // apply the sign to the unsigned quotient
                r_quot <= r_neg ? -$signed({1'b0, r_dvd}) : $signed({1'b0, r_dvd});
                r_fix  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_quot = r_quot;
    assign o_done = r_done;

endmodule

// ===== hw/rtl/tfss_dp.sv =====
// Datapath: coefficient stores, strip scan, column arithmetic and result registers.
`timescale 1ns / 1ps

module tfss_dp
    import tfss_pkg::*;
#(
    parameter int MAX_ORDER = TFSS_MAX_ORDER
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    input  logic               i_coeff_kind,
    input  logic signed [31:0] i_coeff_value,
    input  logic               i_cfg_valid,
    input  logic [15:0]        i_cfg_data,
    output logic               o_valid,
    output logic [3:0]         o_state_index,
    output logic signed [31:0] o_a_value,
    output logic signed [31:0] o_c_value,
    output logic signed [31:0] o_d_value,
    output logic [1:0]         o_status,
    output logic               o_last
);

    localparam int DEPTH = MAX_ORDER + 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int IW    = $clog2(DEPTH);

    logic [15:0]   r_eps;
    logic [CW-1:0] r_num_cnt, r_den_cnt, r_idx, r_ns, r_ds, r_n, r_pad, r_k;
    logic          r_ovf;

    logic signed [31:0]            r_den0, r_p0, r_ndk, r_nk, r_pk;
    logic signed [TFSS_QUOT_W-1:0] r_q;
    logic signed [63:0]            r_prod;
    logic signed [47:0]            r_prodq;

    logic               r_valid, r_last;
    logic [3:0]         r_sidx;
    logic signed [31:0] r_a, r_c, r_d;
    t_status            r_status;

    logic          num_we, den_we;
    logic [IW-1:0] num_raddr, den_raddr;
    logic [31:0]   num_rdata, den_rdata;
    logic [CW-1:0] nl, dl, num_col, den_col, km1;
    logic          k_lt_pad;

    logic                          div_start, div_done;
    logic signed [31:0]            div_x, div_d;
    logic signed [TFSS_QUOT_W-1:0] div_quot;
    logic signed [63:0]            prod_bias;

    assign num_we = i_cmd.load && !i_coeff_kind && (r_num_cnt < CW'(DEPTH));
    assign den_we = i_cmd.load &&  i_coeff_kind && (r_den_cnt < CW'(DEPTH));

    assign nl       = r_num_cnt - r_ns;
    assign dl       = r_den_cnt - r_ds;
    assign num_col  = r_ns + r_k - r_pad;
    assign den_col  = r_ds + r_k;
    assign k_lt_pad = r_k < r_pad;
    assign km1      = r_k - 1'b1;

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_HEAD: begin
                num_raddr = r_ns[IW-1:0];
                den_raddr = r_ds[IW-1:0];
            end
            RD_COL: begin
                num_raddr = num_col[IW-1:0];
                den_raddr = den_col[IW-1:0];
            end
            default: begin
                num_raddr = r_idx[IW-1:0];
                den_raddr = r_idx[IW-1:0];
            end
        endcase
    end

    tfss_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_num_ram (
        .i_clk   (i_clk),
        .i_we    (num_we),
        .i_waddr (r_num_cnt[IW-1:0]),
        .i_wdata (i_coeff_value),
        .i_raddr (num_raddr),
        .o_rdata (num_rdata)
    );

    tfss_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_den_ram (
        .i_clk   (i_clk),
        .i_we    (den_we),
        .i_waddr (r_den_cnt[IW-1:0]),
        .i_wdata (i_coeff_value),
        .i_raddr (den_raddr),
        .o_rdata (den_rdata)
    );

    always_comb begin
        unique case (i_cmd.div_sel)
            DIV_P0: begin
                div_x = num_rdata;
                div_d = den_rdata;
            end
            DIV_DK: begin
                div_x = den_rdata;
                div_d = r_den0;
            end
            default: begin
                div_x = r_nk;
                div_d = r_den0;
            end
        endcase
    end

    assign div_start = i_cmd.div_start;

    tfss_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_x     (div_x),
        .i_d     (div_d),
        .o_quot  (div_quot),
        .o_done  (div_done)
    );

    // bias negative products so the shift truncates toward zero
    assign prod_bias = r_prod + (r_prod[63] ? 64'sd65535 : 64'sd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps     <= 16'd1;
            r_num_cnt <= '0;
            r_den_cnt <= '0;
            r_ovf     <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_eps <= i_cfg_data;
            end
            if (i_cmd.load) begin
                if (num_we) begin
                    r_num_cnt <= r_num_cnt + 1'b1;
                end else if (den_we) begin
                    r_den_cnt <= r_den_cnt + 1'b1;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.cnt_clr) begin
                r_num_cnt <= '0;
                r_den_cnt <= '0;
                r_ovf     <= 1'b0;
            end
            r_valid <= i_cmd.emit || i_cmd.err;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prodq <= 48'(prod_bias >>> 16);
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.ns_set) begin
            r_ns <= r_idx;
        end
        if (i_cmd.ds_set) begin
            r_ds <= r_idx;
        end
        if (i_cmd.chk_set) begin
            r_n   <= dl - 1'b1;
            r_pad <= dl - nl;
        end
        if (i_cmd.den0_set) begin
            r_den0 <= den_rdata;
        end
        if (i_cmd.p0_set) begin
            r_p0 <= sat32(64'(div_quot));
        end else if (i_cmd.p0_clr) begin
            r_p0 <= '0;
        end
        if (i_cmd.k_init) begin
            r_k <= CW'(1);
        end else if (i_cmd.k_inc) begin
            r_k <= r_k + 1'b1;
        end
        if (i_cmd.nk_set) begin
            r_nk <= k_lt_pad ? 32'sd0 : $signed(num_rdata);
        end
        if (i_cmd.q_set) begin
            r_q   <= div_quot;
            r_ndk <= sat32(64'(div_quot));
        end
        if (i_cmd.prod_set) begin
            r_prod <= 64'(r_p0) * 64'(r_ndk);
        end
        if (i_cmd.pk_set) begin
            r_pk <= sat32(64'(div_quot));
        end
        if (i_cmd.emit) begin
            r_sidx   <= 4'(km1);
            r_a      <= sat32(-(64'(r_q)));
            r_c      <= sat32(64'(r_pk) - 64'(r_prodq));
            r_d      <= r_p0;
            r_status <= ST_OK;
            r_last   <= (r_k == r_n);
        end else if (i_cmd.err) begin
            r_sidx   <= '0;
            r_a      <= '0;
            r_c      <= '0;
            r_d      <= '0;
            r_status <= i_cmd.err_code;
            r_last   <= 1'b1;
        end
    end

    always_comb begin
        o_stat.ovf          = r_ovf;
        o_stat.num_scan_end = r_idx >= r_num_cnt;
        o_stat.num_small    = mag32(num_rdata) <= {16'd0, r_eps};
        o_stat.den_scan_end = r_idx >= r_den_cnt;
        o_stat.den_small    = mag32(den_rdata) <= {16'd0, r_eps};
        o_stat.not_proper   = dl < nl;
        o_stat.order_zero   = dl < CW'(2);
        o_stat.pad_zero     = r_pad == '0;
        o_stat.div_done     = div_done;
        o_stat.k_last       = r_k == r_n;
    end

    assign o_valid       = r_valid;
    assign o_state_index = r_sidx;
    assign o_a_value     = r_a;
    assign o_c_value     = r_c;
    assign o_d_value     = r_d;
    assign o_status      = r_status;
    assign o_last        = r_last;

endmodule

// ===== hw/rtl/tfss_ctrl.sv =====
// Controller state machine: load, strip scan, checks and per-column sequencing.
`timescale 1ns / 1ps

module tfss_ctrl
    import tfss_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic     i_load_done,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy
);

    typedef enum logic [14:0] {
        S_IDLE   = 15'b000000000000001,
        S_OVF    = 15'b000000000000010,
        S_NUM_RD = 15'b000000000000100,
        S_NUM_CK = 15'b000000000001000,
        S_DEN_RD = 15'b000000000010000,
        S_DEN_CK = 15'b000000000100000,
        S_CHECK  = 15'b000000001000000,
        S_LD0    = 15'b000000010000000,
        S_P0     = 15'b000000100000000,
        S_RD     = 15'b000001000000000,
        S_DK     = 15'b000010000000000,
        S_DKW    = 15'b000100000000000,
        S_PK     = 15'b001000000000000,
        S_PKW    = 15'b010000000000000,
        S_EMIT   = 15'b100000000000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.err_code = ST_OK;
        o_cmd.rd_sel   = RD_SCAN;
        o_cmd.div_sel  = DIV_P0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_load_done) begin
                        n_state = S_OVF;
                    end
                end
            end
            S_OVF: begin
                if (i_stat.ovf) begin
                    o_cmd.err      = 1'b1;
                    o_cmd.err_code = ST_TOO_MANY;
                    o_cmd.cnt_clr  = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_NUM_RD;
                end
            end
            S_NUM_RD: begin
                if (i_stat.num_scan_end) begin
                    o_cmd.ns_set  = 1'b1;
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_DEN_RD;
                end else begin
                    n_state = S_NUM_CK;
                end
            end
            S_NUM_CK: begin
                if (i_stat.num_small) begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_NUM_RD;
                end else begin
                    o_cmd.ns_set  = 1'b1;
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_DEN_RD;
                end
            end
            S_DEN_RD: begin
                if (i_stat.den_scan_end) begin
                    o_cmd.ds_set = 1'b1;
                    n_state      = S_CHECK;
                end else begin
                    n_state = S_DEN_CK;
                end
            end
            S_DEN_CK: begin
                if (i_stat.den_small) begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_DEN_RD;
                end else begin
                    o_cmd.ds_set = 1'b1;
                    n_state      = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.not_proper) begin
                    o_cmd.err      = 1'b1;
                    o_cmd.err_code = ST_NOT_PROPER;
                    o_cmd.cnt_clr  = 1'b1;
                    n_state        = S_IDLE;
                end else if (i_stat.order_zero) begin
                    o_cmd.err      = 1'b1;
                    o_cmd.err_code = ST_ORDER_ZERO;
                    o_cmd.cnt_clr  = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.chk_set = 1'b1;
                    o_cmd.rd_sel  = RD_HEAD;
                    n_state       = S_LD0;
                end
            end
            S_LD0: begin
                o_cmd.den0_set = 1'b1;
                if (i_stat.pad_zero) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_P0;
                    n_state         = S_P0;
                end else begin
                    o_cmd.p0_clr = 1'b1;
                    o_cmd.k_init = 1'b1;
                    n_state      = S_RD;
                end
            end
            S_P0: begin
                if (i_stat.div_done) begin
                    o_cmd.p0_set = 1'b1;
                    o_cmd.k_init = 1'b1;
                    n_state      = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd_sel = RD_COL;
                n_state      = S_DK;
            end
            S_DK: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_DK;
                o_cmd.nk_set    = 1'b1;
                n_state         = S_DKW;
            end
            S_DKW: begin
                if (i_stat.div_done) begin
                    o_cmd.q_set = 1'b1;
                    n_state     = S_PK;
                end
            end
            S_PK: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_PK;
                o_cmd.prod_set  = 1'b1;
                n_state         = S_PKW;
            end
            S_PKW: begin
                if (i_stat.div_done) begin
                    o_cmd.pk_set = 1'b1;
                    n_state      = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_stat.k_last) begin
                    o_cmd.cnt_clr = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state     = S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = r_state != S_IDLE;

endmodule

// ===== hw/rtl/tf_to_state_space_canonical.sv =====
// Top level: transfer function to controllable canonical state space converter.
// Coefficients load one per cycle (start high while busy is low). The coefficient
// flagged load_done starts a conversion: busy rises, leading coefficients of
// magnitude at most eps are stripped (both polynomials), then one result per
// state is strobed on o_valid for a single cycle; the receiver must take it then.
// The shared 48-step radix-2 divider sets the pace, with two divisions per
// column and one more for D when the numerator is as long as the denominator.
// Error cases give one result with last set. The eps register is written
// through the cfg channel, which is always ready; write it only while no
// conversion is running.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tf_to_state_space_canonical
    import tfss_pkg::*;
#(
    parameter int MAX_ORDER = TFSS_MAX_ORDER
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               busy,
    input  logic               i_coeff_kind,
    input  logic signed [31:0] i_coeff_value,
    input  logic               i_load_done,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_cfg_data,
    output logic               o_valid,
    output logic [3:0]         o_state_index,
    output logic signed [31:0] o_a_value,
    output logic signed [31:0] o_c_value,
    output logic signed [31:0] o_d_value,
    output logic [1:0]         o_status,
    output logic               o_last
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     start_ok;

    assign o_cfg_ready = 1'b1;
    assign start_ok    = i_start && !busy;

    tfss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start_ok),
        .i_load_done (i_load_done),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_busy      (busy)
    );

    tfss_dp #(.MAX_ORDER(MAX_ORDER)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_coeff_kind  (i_coeff_kind),
        .i_coeff_value (i_coeff_value),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .o_state_index (o_state_index),
        .o_a_value     (o_a_value),
        .o_c_value     (o_c_value),
        .o_d_value     (o_d_value),
        .o_status      (o_status),
        .o_last        (o_last)
    );

    `ASSERT_CLK(a_err_is_last, i_clk, i_rst_n, (o_valid && o_status != ST_OK) |-> o_last, "error result without last")
    `ASSERT_CLK(a_done_busy, i_clk, i_rst_n, (i_start && !busy && i_load_done) |=> busy, "final coefficient did not start a conversion")
    `ASSERT_CLK(a_gap_after_last, i_clk, i_rst_n, (o_valid && o_last) |=> !o_valid, "result right after last")
    `ASSERT_CLK(a_valid_from_busy, i_clk, i_rst_n, o_valid |-> $past(busy), "result strobe outside a conversion")

endmodule

// ===== tb/tfss_checker.sv =====
// Checker for the converter: tracks coefficient loads, predicts result columns and compares.
`timescale 1ns / 1ps

module tfss_checker
    import tfss_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic               i_coeff_kind,
    input  logic signed [31:0] i_coeff_value,
    input  logic               i_load_done,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_valid,
    input  logic [3:0]         i_state_index,
    input  logic signed [31:0] i_a_value,
    input  logic signed [31:0] i_c_value,
    input  logic signed [31:0] i_d_value,
    input  logic [1:0]         i_status,
    input  logic               i_last,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int DEPTH = TFSS_MAX_ORDER + 1;

    typedef struct {
        logic [3:0]         idx;
        logic signed [31:0] a;
        logic signed [31:0] c;
        logic signed [31:0] d;
        t_status            st;
        logic               last;
    } t_column;

    t_column     column_q[$];
    longint      num_coef[DEPTH];
    longint      den_coef[DEPTH];
    int          num_len;
    int          den_len;
    bit          ovf;
    logic [15:0] eps;

    assign o_pending = column_q.size();

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint qdiv(input longint x, input longint d);
        return (x * 65536) / d;
    endfunction

    function automatic bit below_eps(input longint v);
        return ((v < 0) ? -v : v) <= longint'(eps);
    endfunction

    task automatic push_column(input int idx, input longint a, input longint c,
                               input longint d, input t_status st, input bit last);
        t_column col;
        col.idx  = 4'(idx);
        col.a    = 32'(a);
        col.c    = 32'(c);
        col.d    = 32'(d);
        col.st   = st;
        col.last = last;
        column_q.push_back(col);
    endtask

    task automatic predict_columns();
        int     ns;
        int     ds;
        int     nl;
        int     dl;
        int     pad;
        int     n;
        longint den0;
        longint p0;
        longint nk;
        longint pk;
        longint q;
        longint ndk;
        longint prod;
        ns = 0;
        ds = 0;
        if (ovf) begin
            push_column(0, 0, 0, 0, ST_TOO_MANY, 1'b1);
            return;
        end
        while (ns < num_len && below_eps(num_coef[ns])) ns++;
        while (ds < den_len && below_eps(den_coef[ds])) ds++;
        nl = num_len - ns;
        dl = den_len - ds;
        if (dl < nl) begin
            push_column(0, 0, 0, 0, ST_NOT_PROPER, 1'b1);
            return;
        end
        if (dl < 2) begin
            push_column(0, 0, 0, 0, ST_ORDER_ZERO, 1'b1);
            return;
        end
        n    = dl - 1;
        pad  = dl - nl;
        den0 = den_coef[ds];
        p0   = (pad == 0) ? clip32(qdiv(num_coef[ns], den0)) : 0;
        for (int k = 1; k <= n; k++) begin
            nk   = (k < pad) ? 0 : num_coef[ns + k - pad];
            pk   = clip32(qdiv(nk, den0));
            q    = qdiv(den_coef[ds + k], den0);
            ndk  = clip32(q);
            prod = (p0 * ndk) / 65536;
            push_column(k - 1, clip32(-q), clip32(pk - prod), p0, ST_OK, k == n);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            eps          <= 16'd1;
            num_len      = 0;
            den_len      = 0;
            ovf          = 1'b0;
            o_fail_count <= 0;
            column_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                eps <= i_cfg_data;
            end
            if (i_start && !i_busy) begin
                if (i_coeff_kind) begin
                    if (den_len < DEPTH) den_coef[den_len++] = longint'(i_coeff_value);
                    else ovf = 1'b1;
                end else begin
                    if (num_len < DEPTH) num_coef[num_len++] = longint'(i_coeff_value);
                    else ovf = 1'b1;
                end
                if (i_load_done) begin
                    predict_columns();
                    num_len = 0;
                    den_len = 0;
                    ovf     = 1'b0;
                end
            end
            if (i_valid) begin
                if (column_q.size() == 0) begin
                    o_fail_count <= o_fail_count + 1;
                    if (o_fail_count < 10) begin
                        $display("unexpected result: idx %0d a %0d c %0d d %0d status %0d last %0b",
                                 i_state_index, i_a_value, i_c_value, i_d_value,
                                 i_status, i_last);
                    end
                end else begin
                    t_column col;
                    col = column_q.pop_front();
                    if (col.idx !== i_state_index || col.a !== i_a_value
                            || col.c !== i_c_value || col.d !== i_d_value
                            || col.st !== t_status'(i_status) || col.last !== i_last) begin
                        o_fail_count <= o_fail_count + 1;
                        if (o_fail_count < 10) begin
                            $display("mismatch exp: idx %0d a %0d c %0d d %0d status %0d last %0b",
                                     col.idx, col.a, col.c, col.d, col.st, col.last);
                            $display("         got: idx %0d a %0d c %0d d %0d status %0d last %0b",
                                     i_state_index, i_a_value, i_c_value, i_d_value,
                                     i_status, i_last);
                        end
                    end
                end
            end
        end
    end

endmodule

// ===== tb/tf_to_state_space_canonical_tb.sv =====
// Testbench top: clock, reset, coefficient and eps stimulus, verdict.
`timescale 1ns / 1ps

module tf_to_state_space_canonical_tb;
    import tfss_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN       = 300;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               coeff_kind;
    logic signed [31:0] coeff_value;
    logic               load_done;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [15:0]        cfg_data;
    logic               res_valid;
    logic [3:0]         state_index;
    logic signed [31:0] a_value;
    logic signed [31:0] c_value;
    logic signed [31:0] d_value;
    logic [1:0]         status;
    logic               last;
    int                 fail_count;
    int                 pending;
    int                 cycles;
    int                 sent;
    int                 burst_left;

    logic signed [31:0] num_list[$];
    logic signed [31:0] den_list[$];

    tf_to_state_space_canonical i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_start       (start),
        .busy          (busy),
        .i_coeff_kind  (coeff_kind),
        .i_coeff_value (coeff_value),
        .i_load_done   (load_done),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .o_valid       (res_valid),
        .o_state_index (state_index),
        .o_a_value     (a_value),
        .o_c_value     (c_value),
        .o_d_value     (d_value),
        .o_status      (status),
        .o_last        (last)
    );

    tfss_checker i_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_coeff_kind  (coeff_kind),
        .i_coeff_value (coeff_value),
        .i_load_done   (load_done),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .i_valid       (res_valid),
        .i_state_index (state_index),
        .i_a_value     (a_value),
        .i_c_value     (c_value),
        .i_d_value     (d_value),
        .i_status      (status),
        .i_last        (last),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tf_to_state_space_canonical_tb: errors");
            $finish;
        end
    end

    // Drive one coefficient and hold it until the transaction completes.
    task automatic send_coeff(input logic kind, input logic signed [31:0] value,
                              input logic done);
        int gap;
        @(negedge clk);
        start       <= 1'b1;
        coeff_kind  <= kind;
        coeff_value <= value;
        load_done   <= done;
        do @(posedge clk); while (busy);
        sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                @(negedge clk);
                start <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    // Load the queued numerator and denominator in random interleaving; last one closes.
    task automatic load_system();
        int total;
        bit pick_den;
        total = num_list.size() + den_list.size();
        for (int i = 0; i < total; i++) begin
            if (num_list.size() == 0) pick_den = 1'b1;
            else if (den_list.size() == 0) pick_den = 1'b0;
            else pick_den = $urandom_range(0, 1);
            if (pick_den) send_coeff(1'b1, den_list.pop_front(), i == total - 1);
            else send_coeff(1'b0, num_list.pop_front(), i == total - 1);
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0 || busy) @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    task automatic write_eps(input logic [15:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [31:0] rand_coeff();
        logic signed [31:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            default: v = $urandom_range(0, 1 << 21) - (1 << 20);
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] rand_lead();
        logic signed [31:0] v;
        if ($urandom_range(0, 7) == 0) v = $urandom;
        else v = $urandom_range(1 << 16, 1 << 20);
        if ($urandom_range(0, 1)) v = -v;
        return v;
    endfunction

    function automatic logic signed [31:0] near_zero(input logic [15:0] eps);
        logic signed [31:0] v;
        v = $urandom_range(0, eps);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    task automatic random_system(input logic [15:0] eps);
        int mode;
        int dl;
        int nl;
        mode = $urandom_range(0, 19);
        if (mode == 0) begin
            // overrun one store
            nl = $urandom_range(0, 3);
            dl = $urandom_range(18, 19);
            if ($urandom_range(0, 1)) begin
                int t;
                t  = nl;
                nl = dl;
                dl = t;
            end
            repeat (nl) num_list.push_back(rand_coeff());
            repeat (dl) den_list.push_back(rand_coeff());
        end else if (mode == 1) begin
            repeat ($urandom_range(0, 3)) num_list.push_back(rand_coeff());
            repeat ($urandom_range(1, 3)) den_list.push_back(rand_coeff());
        end else begin
            dl = ($urandom_range(0, 9) == 0) ? 17 : $urandom_range(1, 5);
            nl = $urandom_range(0, dl);
            if ($urandom_range(0, 9) == 0) nl = dl + 1;
            repeat ($urandom_range(0, 2)) den_list.push_back(near_zero(eps));
            if (dl + den_list.size() > 17) dl = 17 - den_list.size();
            den_list.push_back(rand_lead());
            repeat (dl - 1) den_list.push_back(rand_coeff());
            repeat ($urandom_range(0, 1)) num_list.push_back(near_zero(eps));
            if (nl > 0) num_list.push_back(rand_lead());
            for (int i = 1; i < nl && num_list.size() < 17; i++)
                num_list.push_back(rand_coeff());
        end
        if (num_list.size() + den_list.size() == 0) den_list.push_back(rand_coeff());
        load_system();
    endtask

    initial begin
        logic [15:0] eps_now;
        rst_n       = 1'b0;
        start       = 1'b0;
        coeff_kind  = 1'b0;
        coeff_value = '0;
        load_done   = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        cycles      = 0;
        sent        = 0;
        burst_left  = 0;
        eps_now     = 16'd1;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // first order, strictly proper
        num_list = '{32'sh0001_0000};
        den_list = '{32'sh0001_0000, 32'sh0002_0000};
        load_system();
        // equal lengths give a nonzero feedthrough
        num_list = '{32'sh0000_8000, 32'sh0001_0000, -32'sh0000_4000};
        den_list = '{32'sh0001_0000, 32'sh0003_0000, 32'sh0002_0000};
        load_system();
        // order zero
        den_list = '{32'sh0001_0000};
        load_system();
        // empty denominator
        num_list = '{32'sh0000_0000};
        load_system();
        // not proper
        num_list = '{32'sh0001_0000, 32'sh0001_0000};
        den_list = '{32'sh0001_0000};
        load_system();
        // extreme values, saturating quotients
        num_list = '{32'sh8000_0000, 32'sh7fff_ffff};
        den_list = '{32'sh0000_0002, 32'sh8000_0000};
        load_system();
        // leading coefficients at or below eps are stripped
        num_list = '{32'sh0000_0000, -32'sh0000_0001, 32'sh0000_0005};
        den_list = '{32'sh0000_0001, -32'sh0000_0001, 32'sh0001_0000, 32'sh0000_0003};
        load_system();

        // hold until every column has come back
        wait_idle();

        while (sent < 130) begin
            if (sent >= 30 && sent < 60 && eps_now != 16'd0) begin
                eps_now = 16'd0;
                write_eps(eps_now);
            end else if (sent >= 60 && sent < 90 && eps_now != 16'd65535) begin
                eps_now = 16'd65535;
                write_eps(eps_now);
            end else if (sent >= 90 && sent < 110 && eps_now == 16'd65535) begin
                eps_now = 16'($urandom_range(2, 65534));
                write_eps(eps_now);
            end else if (sent >= 110 && eps_now != 16'd1) begin
                eps_now = 16'd1;
                write_eps(eps_now);
            end
            random_system(eps_now);
        end

        @(negedge clk);
        start <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN) @(negedge clk);
        if (fail_count == 0) begin
            $display("tf_to_state_space_canonical_tb: clean");
        end else begin
            $display("tf_to_state_space_canonical_tb: errors");
        end
        $finish;
    end

endmodule
